// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the framer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold in the same cycle as the trigger.
`define SFR_ASSERT_SAME(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("sfr assertion failed");

// The condition must hold in the cycle after the trigger.
`define SFR_ASSERT_NEXT(lbl, clk, rst, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("sfr assertion failed");

`endif

// ----- rtl/sfr_pkg.sv -----
package sfr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned LEN_IN_W    = 10;
  localparam int unsigned LEN_HDR_W   = 16;
  localparam int unsigned SYNC_W      = 32;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned APB_ADDR_W  = 2;
  localparam int unsigned APB_DATA_W  = 32;

  localparam logic [SYNC_W-1:0]    SYNC_RESET = 32'hDEADBEEF;
  localparam logic [31:0]          CRC_POLY   = 32'hEDB88320;
  localparam logic [31:0]          CRC_ONES   = 32'hFFFFFFFF;
  localparam logic [LEN_HDR_W-1:0] MAX_LEN    = 16'd512;

  localparam logic [APB_ADDR_W-1:0] REG_SYNC_ADDR = 2'd0;

  typedef struct packed {
    logic [BYTE_W-1:0]    data;
    logic [LEN_HDR_W-1:0] len;
    logic [SYNC_W-1:0]    sync;
    logic                 first;
    logic                 last;
  } cmd_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? (CRC_POLY ^ (r >> 1)) : (r >> 1);
    end
    return r;
  endfunction

endpackage

// ----- rtl/sfr_front.sv -----
module sfr_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              push,
  output logic                              full,
  input  logic [sfr_pkg::BYTE_W-1:0]        payload_byte,
  input  logic [sfr_pkg::LEN_IN_W-1:0]      frame_length,
  input  logic                              payload_last,
  input  logic [sfr_pkg::SYNC_W-1:0]        sync_pattern,
  input  logic                              q_full,
  output logic                              q_push,
  output sfr_pkg::cmd_t                     q_cmd
);

  logic                             frame_open;
  logic [sfr_pkg::LEN_HDR_W-1:0]    len_ext;

  always_comb begin
    len_ext = {{(sfr_pkg::LEN_HDR_W - sfr_pkg::LEN_IN_W){1'b0}}, frame_length};
    q_cmd.data  = payload_byte;
    q_cmd.len   = (len_ext > sfr_pkg::MAX_LEN) ? sfr_pkg::MAX_LEN : len_ext;
    q_cmd.sync  = sync_pattern;
    q_cmd.first = !frame_open;
    q_cmd.last  = payload_last;
  end

  assign full   = q_full;
  assign q_push = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_open <= 1'b0;
    end else if (q_push) begin
      frame_open <= !payload_last;
    end
  end

endmodule

// ----- rtl/sfr_queue.sv -----
`include "assert_macros.svh"

module sfr_queue #(
  parameter int unsigned Depth = sfr_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  sfr_pkg::cmd_t wr_cmd,
  output logic          q_full,
  input  logic          rd_en,
  output logic          rd_valid,
  output sfr_pkg::cmd_t rd_cmd
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  sfr_pkg::cmd_t   store [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign q_full   = (count == CntFull);
  assign rd_valid = (count != '0);
  assign rd_cmd   = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_en && !rd_en) begin
        count <= count + 1'b1;
      end else if (rd_en && !wr_en) begin
        count <= count - 1'b1;
      end
    end
  end

  `SFR_ASSERT_SAME(a_no_read_empty, clk, rst, rd_en, rd_valid)
  `SFR_ASSERT_SAME(a_count_bound, clk, rst, 1'b1, count <= CntFull)

endmodule

// ----- rtl/sfr_back.sv -----
`include "assert_macros.svh"

module sfr_back (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  sfr_pkg::cmd_t               q_cmd,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output logic [sfr_pkg::BYTE_W-1:0]  out_byte,
  output logic                        run_last,
  output logic                        frame_end
);

  typedef enum logic [1:0] {
    PH_SYNC,
    PH_LEN,
    PH_DATA,
    PH_CRC
  } phase_t;

  phase_t      phase;
  phase_t      phase_eff;
  phase_t      phase_next;
  logic [1:0]  idx;
  logic [1:0]  idx_eff;
  logic [1:0]  idx_next;
  logic        mid;
  logic        out_valid;
  logic [31:0] crc;
  logic [31:0] crc_base;
  logic [31:0] crc_next;
  logic [31:0] crc_fin;
  logic [7:0]  byte_sel;
  logic        done;
  logic        adv;

  always_comb begin
    phase_eff = mid ? phase : (q_cmd.first ? PH_SYNC : PH_DATA);
    idx_eff   = mid ? idx : 2'd0;
    crc_base  = (!mid && q_cmd.first) ? sfr_pkg::CRC_ONES : crc;
    crc_fin   = ~crc_base;
    done       = 1'b0;
    phase_next = phase_eff;
    idx_next   = idx_eff + 2'd1;
    case (phase_eff)
      PH_SYNC: begin
        byte_sel = 8'(q_cmd.sync >> {~idx_eff, 3'b000});
        if (idx_eff == 2'd3) begin
          phase_next = PH_LEN;
          idx_next   = 2'd0;
        end
      end
      PH_LEN: begin
        byte_sel = idx_eff[0] ? q_cmd.len[7:0] : q_cmd.len[15:8];
        if (idx_eff[0]) begin
          phase_next = PH_DATA;
          idx_next   = 2'd0;
        end
      end
      PH_DATA: begin
        byte_sel = q_cmd.data;
        idx_next = 2'd0;
        if (q_cmd.last) begin
          phase_next = PH_CRC;
        end else begin
          done = 1'b1;
        end
      end
      PH_CRC: begin
        byte_sel = 8'(crc_fin >> {idx_eff, 3'b000});
        if (idx_eff == 2'd3) begin
          done = 1'b1;
        end
      end
      default: begin
        byte_sel = '0;
        done     = 1'b1;
      end
    endcase
    crc_next = (phase_eff == PH_CRC) ? crc_base : sfr_pkg::crc_byte(crc_base, byte_sel);
  end

  assign adv   = q_valid && (!out_valid || pop);
  assign q_pop = adv && done;
  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid       <= 1'b0;
      phase     <= PH_DATA;
      idx       <= 2'd0;
      out_valid <= 1'b0;
    end else if (adv) begin
      mid       <= !done;
      phase     <= phase_next;
      idx       <= idx_next;
      crc       <= crc_next;
      out_byte  <= byte_sel;
      run_last  <= done;
      frame_end <= done && (phase_eff == PH_CRC);
      out_valid <= 1'b1;
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  `SFR_ASSERT_SAME(a_end_is_last, clk, rst, out_valid && frame_end, run_last)
  `SFR_ASSERT_NEXT(a_stay_mid, clk, rst, adv && !done, mid)
  `SFR_ASSERT_SAME(a_mid_needs_entry, clk, rst, mid, q_valid)

endmodule

// ----- rtl/sync_length_crc32_framer_core.sv -----
// Channel   Handshake          Beat contents
// input     push / full        payload_byte, frame_length, payload_last
// result    pop / empty        out_byte, run_last, frame_end
// config    APB psel/penable   sync_pattern at byte address 0
//
// A middle payload byte yields one beat, so such bytes stream at one beat per cycle
// while pop is high. A first byte adds four sync and two length bytes before it, a
// last byte four CRC bytes after it, from the one-byte-per-cycle output sequencer;
// the input queue absorbs these bursts. Reset is synchronous and active high and clears
// the queue, frame state and output. A stall on the result side holds the output
// register, and input stops only when the queue is full.
module sync_length_crc32_framer_core #(
  parameter int unsigned QueueDepth = sfr_pkg::QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             push,
  output logic                             full,
  input  logic [sfr_pkg::BYTE_W-1:0]       payload_byte,
  input  logic [sfr_pkg::LEN_IN_W-1:0]     frame_length,
  input  logic                             payload_last,
  output logic                             empty,
  input  logic                             pop,
  output logic [sfr_pkg::BYTE_W-1:0]       out_byte,
  output logic                             run_last,
  output logic                             frame_end,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [sfr_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [sfr_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [sfr_pkg::APB_DATA_W-1:0]   prdata,
  output logic                             pready
);

  logic [sfr_pkg::SYNC_W-1:0] sync_pattern;
  logic                       q_full;
  logic                       q_push;
  logic                       q_pop;
  logic                       q_valid;
  sfr_pkg::cmd_t              wr_cmd;
  sfr_pkg::cmd_t              rd_cmd;

  assign pready = 1'b1;
  assign prdata = (paddr == sfr_pkg::REG_SYNC_ADDR) ? sync_pattern : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_pattern <= sfr_pkg::SYNC_RESET;
    end else if (psel && penable && pwrite && pready && (paddr == sfr_pkg::REG_SYNC_ADDR)) begin
      sync_pattern <= pwdata;
    end
  end

  sfr_front u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .payload_last (payload_last),
    .sync_pattern (sync_pattern),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_cmd        (wr_cmd)
  );

  sfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (q_push),
    .wr_cmd   (wr_cmd),
    .q_full   (q_full),
    .rd_en    (q_pop),
    .rd_valid (q_valid),
    .rd_cmd   (rd_cmd)
  );

  sfr_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (rd_cmd),
    .q_pop     (q_pop),
    .empty     (empty),
    .pop       (pop),
    .out_byte  (out_byte),
    .run_last  (run_last),
    .frame_end (frame_end)
  );

endmodule

// ----- tb/sv/testbench.sv -----
module testbench;

  localparam int STALL_LIMIT = 2000;
  localparam int SCRIPT_ROWS = 20;

  typedef enum logic {ROW_BEAT, ROW_SYNC} row_kind_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [7:0]  data;
    logic [9:0]  len;
    logic        last;
    logic        typed;
    logic [31:0] sync;
    logic [15:0] hdr;
  } row_t;

  typedef struct packed {
    logic [7:0] data;
    logic       run_last;
    logic       frame_end;
  } beat_t;

  logic                           clk;
  logic                           rst;
  logic                           push;
  logic                           full;
  logic [sfr_pkg::BYTE_W-1:0]     payload_byte;
  logic [sfr_pkg::LEN_IN_W-1:0]   frame_length;
  logic                           payload_last;
  logic                           empty;
  logic                           pop;
  logic [sfr_pkg::BYTE_W-1:0]     out_byte;
  logic                           run_last;
  logic                           frame_end;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [sfr_pkg::APB_ADDR_W-1:0] paddr;
  logic [sfr_pkg::APB_DATA_W-1:0] pwdata;
  logic [sfr_pkg::APB_DATA_W-1:0] prdata;
  logic                           pready;

  logic        typed_hdr;
  logic [31:0] typed_sync;
  logic [15:0] typed_len;

  bit          in_fire;
  bit          out_fire;
  bit          apb_fire;
  int          mismatches;
  int          beats_seen;
  int          quiet_cycles;
  int          items_sent;
  int          burst_left;
  bit          steady;

  logic [31:0] sync_shadow;
  logic [31:0] crc_state;
  bit          frame_active;
  beat_t       expected_beats[$];
  row_t        script[SCRIPT_ROWS];

  sync_length_crc32_framer_core dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .payload_byte (payload_byte),
    .frame_length (frame_length),
    .payload_last (payload_last),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .run_last     (run_last),
    .frame_end    (frame_end),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    logic        fb;
    r = c;
    for (int i = 0; i < 8; i++) begin
      fb = r[0] ^ b[i];
      r = r >> 1;
      if (fb) begin
        r = r ^ sfr_pkg::CRC_POLY;
      end
    end
    return r;
  endfunction

  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%s", msg);
    end
  endtask

  // Builds the framed beats that one payload byte causes and queues them.
  task automatic frame_payload(input logic [7:0] data, input logic [9:0] len,
                               input logic last, input logic typed,
                               input logic [31:0] tsync, input logic [15:0] thdr);
    logic [7:0]  seq[11];
    int          n;
    logic [15:0] hdr;
    logic [31:0] sw;
    logic [31:0] crc_out;
    beat_t       bt;
    n = 0;
    if (!frame_active) begin
      crc_state = sfr_pkg::CRC_ONES;
      hdr = ({6'd0, len} > sfr_pkg::MAX_LEN) ? sfr_pkg::MAX_LEN : {6'd0, len};
      sw = sync_shadow;
      if (typed) begin
        sw = tsync;
        hdr = thdr;
      end
      for (int i = 3; i >= 0; i--) begin
        seq[n] = sw[8*i +: 8];
        n = n + 1;
      end
      seq[n] = hdr[15:8];
      seq[n+1] = hdr[7:0];
      n = n + 2;
      frame_active = 1'b1;
    end
    seq[n] = data;
    n = n + 1;
    for (int k = 0; k < n; k++) begin
      crc_state = crc_step(crc_state, seq[k]);
    end
    if (last) begin
      crc_out = ~crc_state;
      for (int i = 0; i < 4; i++) begin
        seq[n+i] = crc_out[8*i +: 8];
      end
      n = n + 4;
      crc_state = sfr_pkg::CRC_ONES;
      frame_active = 1'b0;
    end
    for (int k = 0; k < n; k++) begin
      bt.data = seq[k];
      bt.run_last = (k == n - 1);
      bt.frame_end = last && (k == n - 1);
      expected_beats.insert(expected_beats.size(), bt);
    end
  endtask

  always @(posedge clk) begin : monitor
    beat_t want;
    in_fire = !rst && push && !full;
    out_fire = !rst && pop && !empty;
    apb_fire = !rst && psel && penable && pready;
    if (rst) begin
      sync_shadow = sfr_pkg::SYNC_RESET;
      crc_state = sfr_pkg::CRC_ONES;
      frame_active = 1'b0;
    end
    if (out_fire) begin
      beats_seen++;
      if (expected_beats.size() == 0) begin
        flag($sformatf("beat %0d: unexpected %02h/%b/%b", beats_seen, out_byte, run_last,
                       frame_end));
      end else begin
        want = expected_beats.pop_front();
        if (out_byte !== want.data || run_last !== want.run_last ||
            frame_end !== want.frame_end) begin
          flag($sformatf("beat %0d: expected %02h/%b/%b, got %02h/%b/%b", beats_seen,
                         want.data, want.run_last, want.frame_end, out_byte, run_last,
                         frame_end));
        end
      end
    end
    if (apb_fire && paddr == sfr_pkg::REG_SYNC_ADDR) begin
      if (pwrite) begin
        sync_shadow = pwdata;
      end else if (prdata !== sync_shadow) begin
        flag($sformatf("sync readback: expected %08h, got %08h", sync_shadow, prdata));
      end
    end
    if (in_fire) begin
      frame_payload(payload_byte, frame_length, payload_last, typed_hdr, typed_sync,
                    typed_len);
    end
    if (!rst) begin
      if (in_fire || out_fire || apb_fire) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles == STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin : receiver
    int pct;
    int left;
    pop = 1'b0;
    pct = 100;
    left = 0;
    do @(negedge clk); while (rst);
    forever begin
      if (left == 0) begin
        left = $urandom_range(20, 80);
        case ($urandom_range(0, 4))
          0, 1: pct = 100;
          2: pct = 70;
          3: pct = 35;
          default: pct = 10;
        endcase
      end
      left--;
      pop <= ($urandom_range(1, 100) <= pct);
      @(negedge clk);
    end
  end

  task automatic send_item(input logic [7:0] data, input logic [9:0] len, input logic last,
                           input logic typed, input logic [31:0] tsync,
                           input logic [15:0] thdr);
    push <= 1'b1;
    payload_byte <= data;
    frame_length <= len;
    payload_last <= last;
    typed_hdr <= typed;
    typed_sync <= tsync;
    typed_len <= thdr;
    do @(negedge clk); while (!in_fire);
    items_sent++;
  endtask

  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(1, 16);
      if (!steady) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
  endtask

  task automatic drain();
    push <= 1'b0;
    while (expected_beats.size() != 0) @(negedge clk);
  endtask

  task automatic apb_xfer(input logic write, input logic [sfr_pkg::APB_ADDR_W-1:0] addr,
                          input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= write;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!apb_fire);
  endtask

  task automatic set_sync(input logic [31:0] value);
    apb_xfer(1'b1, sfr_pkg::REG_SYNC_ADDR, value);
    apb_xfer(1'b0, sfr_pkg::REG_SYNC_ADDR, '0);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_frame();
    int          nb;
    int          shape;
    logic [9:0]  lf;
    nb = 0;
    shape = $urandom_range(0, 19);
    steady = ($urandom_range(0, 4) == 0);
    nb = (shape == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
    lf = 10'(nb);
    if (shape >= 16) begin
      lf = 10'($urandom_range(0, 1023));
    end
    for (int k = 0; k < nb; k++) begin
      send_item(8'($urandom_range(0, 255)),
                (k == 0 || $urandom_range(0, 1)) ? lf : 10'($urandom_range(0, 1023)),
                k == nb - 1, 1'b0, '0, '0);
      pace_sender();
    end
  endtask

  initial begin : stimulus
    int target;
    rst = 1'b1;
    push = 1'b0;
    payload_byte = '0;
    frame_length = '0;
    payload_last = 1'b0;
    typed_hdr = 1'b0;
    typed_sync = '0;
    typed_len = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    beats_seen = 0;
    quiet_cycles = 0;
    items_sent = 0;
    burst_left = 0;
    steady = 1'b0;
    script = '{
      '{ROW_BEAT, 8'h00, 10'd1,    1'b1, 1'b1, 32'hDEADBEEF, 16'd1},
      '{ROW_BEAT, 8'hFF, 10'd1023, 1'b0, 1'b1, 32'hDEADBEEF, 16'd512},
      '{ROW_BEAT, 8'hA5, 10'd0,    1'b0, 1'b0, 32'h0,        16'd0},
      '{ROW_BEAT, 8'h5A, 10'd7,    1'b1, 1'b0, 32'h0,        16'd0},
      '{ROW_BEAT, 8'h3C, 10'd0,    1'b1, 1'b1, 32'hDEADBEEF, 16'd0},
      '{ROW_BEAT, 8'h01, 10'd512,  1'b0, 1'b1, 32'hDEADBEEF, 16'd512},
      '{ROW_BEAT, 8'h80, 10'd513,  1'b1, 1'b0, 32'h0,        16'd0},
      '{ROW_BEAT, 8'h7F, 10'd513,  1'b1, 1'b1, 32'hDEADBEEF, 16'd512},
      '{ROW_SYNC, 8'h00, 10'd0,    1'b0, 1'b0, 32'h00000000, 16'd0},
      '{ROW_BEAT, 8'h55, 10'd2,    1'b0, 1'b1, 32'h00000000, 16'd2},
      '{ROW_SYNC, 8'h00, 10'd0,    1'b0, 1'b0, 32'hFFFFFFFF, 16'd0},
      '{ROW_BEAT, 8'hAA, 10'd300,  1'b1, 1'b0, 32'h0,        16'd0},
      '{ROW_BEAT, 8'h12, 10'd3,    1'b0, 1'b1, 32'hFFFFFFFF, 16'd3},
      '{ROW_BEAT, 8'h34, 10'd511,  1'b0, 1'b0, 32'h0,        16'd0},
      '{ROW_BEAT, 8'hFE, 10'd256,  1'b1, 1'b0, 32'h0,        16'd0},
      '{ROW_SYNC, 8'h00, 10'd0,    1'b0, 1'b0, 32'h12345678, 16'd0},
      '{ROW_BEAT, 8'h9C, 10'd255,  1'b1, 1'b1, 32'h12345678, 16'd255},
      '{ROW_BEAT, 8'hC3, 10'd1,    1'b1, 1'b0, 32'h0,        16'd0},
      '{ROW_SYNC, 8'h00, 10'd0,    1'b0, 1'b0, 32'hDEADBEEF, 16'd0},
      '{ROW_BEAT, 8'h6E, 10'd1023, 1'b1, 1'b1, 32'hDEADBEEF, 16'd512}
    };
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    for (int i = 0; i < SCRIPT_ROWS; i++) begin
      if (script[i].kind == ROW_SYNC) begin
        drain();
        set_sync(script[i].sync);
      end else begin
        send_item(script[i].data, script[i].len, script[i].last, script[i].typed,
                  script[i].sync, script[i].hdr);
        pace_sender();
      end
    end

    // Each phase starts from an empty pipeline with a fresh sync word.
    for (int p = 0; p < 3; p++) begin
      drain();
      set_sync($urandom());
      target = items_sent + 85;
      while (items_sent < target) begin
        random_frame();
      end
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/sfr_pkg.sv
rtl/sfr_front.sv
rtl/sfr_queue.sv
rtl/sfr_back.sv
rtl/sync_length_crc32_framer_core.sv
tb/sv/testbench.sv
